// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the 3x3 morphology block.
// No dependencies; simulation sees the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, idle while reset is low.
`define BM3_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bm3 assertion failed");

// Check that an antecedent is followed by a consequent in the next cycle.
`define BM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bm3 assertion failed");

`else

`define BM3_ASSERT(lbl, clk, rst_n, prop)
`define BM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/bm3_pkg.sv -----
// Package for the 3x3 binary morphology block: field widths, register
// indexes, reset values and the dimension clamp. No dependencies.
package bm3_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERODE_MODE   = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;

  // Map a written dimension to the one in effect: zero acts as one,
  // anything above the maximum acts as the maximum.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] value,
                                            input int unsigned max_dim);
    int unsigned res;
    res = int'(value);
    if (value == '0) begin
      res = 1;
    end else if (res > max_dim) begin
      res = max_dim;
    end
    return res;
  endfunction

endpackage

// ----- src/binary_morphology_3x3.sv -----
// Top level of the streaming 3x3 binary dilation / erosion block.
// Depends on bm3_pkg and assert_macros.svh.
//
// Usage:
//   Pixels arrive in raster order on the input channel (in_valid_i /
//   in_ready_o, pixel_in_i, drain_i); any nonzero pixel is foreground.
//   A frame takes image_width*image_height pixel transfers followed by
//   image_width+1 drain transfers that flush the pending results.
//   Each transfer from pixel (1,1) of the input stream on yields one result
//   on the output channel (out_valid_o / out_ready_i) with its row, column
//   and a frame_last flag on the final pixel. The next transfer after the
//   one that produced frame_last starts a new frame.
//   The transfer that completes a window, image_width+1 transfers after
//   its own pixel went in, feeds the window stage and then the result register.
//   Throughput: one transfer per cycle unless the window stage is held; the
//   line memory is read when an item is taken, written as it leaves the
//   window stage, bypassed in the one-column case where both hit one address.
//   The user must make configuration writes (cfg_valid_i / cfg_ready_o, always
//   ready) while idle, which the block does not enforce; used indexes restart the frame.
//   Reset clears counters, window and registers to their defaults; the
//   line memory is not cleared, since unwritten columns only feed window
//   taps that lie outside the image.
//   A stalled receiver holds the result register; one more item is then
//   taken into the window stage before the input channel backs up.
`include "assert_macros.svh"

module binary_morphology_3x3 #(
  parameter int unsigned MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bm3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bm3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bm3_pkg::CFG_W-1:0]       cfg_data_i,
  // pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bm3_pkg::PIX_W-1:0]       pixel_in_i,
  input  logic                            drain_i,
  // result output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_pixel_o,
  output logic [bm3_pkg::COORD_W-1:0]     result_row_o,
  output logic [bm3_pkg::COORD_W-1:0]     result_col_o,
  output logic                            frame_last_o
);

  localparam int unsigned CB = $clog2(MAX_WIDTH);       // column index
  localparam int unsigned WB = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int unsigned HB = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int unsigned RB = $clog2(MAX_HEIGHT + 2);  // row counters

  // Effective configuration
  logic [WB-1:0] eff_w_q;
  logic [HB-1:0] eff_h_q;
  logic          erode_q;

  // Input side counters
  logic [CB-1:0] in_col_q, in_col_d;
  logic [RB-1:0] in_row_q, in_row_d;

  // Window stage (one item)
  logic          s1_valid_q, s1_valid_d;
  logic          s1_emit_q;
  logic          s1_bot_q;
  logic [CB-1:0] s1_col_q;
  logic [1:0]    s1_lines_q;   // {older row, newer row} at this column

  // 3x3 window [row][col], center at [1][1]
  logic [2:0][2:0] window_q, window_d, win_shift;

  // Output side counters
  logic [RB-1:0] out_row_q, out_row_d;
  logic [CB-1:0] out_col_q, out_col_d;

  // Result register
  logic                        out_valid_q, out_valid_d;
  logic                        res_pix_q;
  logic [bm3_pkg::COORD_W-1:0] res_row_q, res_col_q;
  logic                        res_last_q;

  // Line memory: bit 1 is the older row, bit 0 the newer row.
  logic [1:0] line_mem [MAX_WIDTH];

  logic cfg_fire, in_fire, s1_go, res_load;
  logic in_col_end, in_frame_end, in_emit, in_bottom, lines_bypass;
  logic out_row_first, out_row_end, out_col_first, out_col_end, out_last;
  logic acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Advance the window stage unless its result would overwrite a held one.
  assign s1_go      = s1_valid_q && (!s1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_load   = s1_go && s1_emit_q;

  // ---------------------------------------------------------------------
  // Input side: position of the incoming item and its foreground bit
  // ---------------------------------------------------------------------
  assign in_col_end   = (32'(in_col_q) + 32'd1) == 32'(eff_w_q);
  assign in_frame_end = (32'(in_row_q) == (32'(eff_h_q) + 32'd1)) && (in_col_q == '0);
  assign in_emit      = (in_row_q >= RB'(2)) || ((in_row_q == RB'(1)) && (in_col_q != '0));
  // Pixels past the last row, and drain items, count as background.
  assign in_bottom    = (32'(in_row_q) < 32'(eff_h_q)) && !drain_i && (pixel_in_i != '0);
  // The window stage writes the same column this cycle only when width is one.
  assign lines_bypass = s1_valid_q && (s1_col_q == in_col_q);

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (cfg_fire) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (in_fire) begin
      if (in_frame_end) begin
        // the item that yields frame_last closes the frame
        in_col_d = '0;
        in_row_d = '0;
      end else if (in_col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + RB'(1);
      end else begin
        in_col_d = in_col_q + CB'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Window stage: shift in the new column and reduce the 3x3 square
  // ---------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_shift[r][0] = window_q[r][1];
      win_shift[r][1] = window_q[r][2];
    end
    win_shift[0][2] = s1_lines_q[1];
    win_shift[1][2] = s1_lines_q[0];
    win_shift[2][2] = s1_bot_q;
  end

  assign out_row_first = (out_row_q == '0);
  assign out_row_end   = (32'(out_row_q) + 32'd1) == 32'(eff_h_q);
  assign out_col_first = (out_col_q == '0);
  assign out_col_end   = (32'(out_col_q) + 32'd1) == 32'(eff_w_q);
  assign out_last      = out_row_end && out_col_end;

  // Skip taps outside the image; erosion ANDs, dilation ORs.
  always_comb begin
    logic tap_ok;
    acc = erode_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap_ok = !((r == 0 && out_row_first) || (r == 2 && out_row_end) ||
                   (c == 0 && out_col_first) || (c == 2 && out_col_end));
        if (tap_ok) begin
          if (erode_q) begin
            acc = acc & win_shift[r][c];
          end else begin
            acc = acc | win_shift[r][c];
          end
        end
      end
    end
  end

  always_comb begin
    window_d  = window_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (cfg_fire) begin
      window_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
    end else if (s1_go) begin
      window_d = win_shift;
      if (s1_emit_q) begin
        if (out_last) begin
          window_d  = '0;
          out_row_d = '0;
          out_col_d = '0;
        end else if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + RB'(1);
        end else begin
          out_col_d = out_col_q + CB'(1);
        end
      end
    end
  end

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_go);
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q     <= WB'(bm3_pkg::clamp_dim(bm3_pkg::RST_IMAGE_WIDTH, MAX_WIDTH));
      eff_h_q     <= HB'(bm3_pkg::clamp_dim(bm3_pkg::RST_IMAGE_HEIGHT, MAX_HEIGHT));
      erode_q     <= 1'b0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      window_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index_i)
          bm3_pkg::CFG_IMAGE_WIDTH: begin
            eff_w_q <= WB'(bm3_pkg::clamp_dim(cfg_data_i, MAX_WIDTH));
          end
          bm3_pkg::CFG_IMAGE_HEIGHT: begin
            eff_h_q <= HB'(bm3_pkg::clamp_dim(cfg_data_i, MAX_HEIGHT));
          end
          bm3_pkg::CFG_ERODE_MODE: begin
            erode_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
      // a write to an unused index leaves the frame running
      if (!cfg_fire || cfg_index_i == bm3_pkg::CFG_IMAGE_WIDTH ||
          cfg_index_i == bm3_pkg::CFG_IMAGE_HEIGHT ||
          cfg_index_i == bm3_pkg::CFG_ERODE_MODE) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
        window_q  <= window_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers and line memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q <= in_emit;
      s1_bot_q  <= in_bottom;
      s1_col_q  <= in_col_q;
      if (lines_bypass) begin
        s1_lines_q <= {s1_lines_q[0], s1_bot_q};
      end else begin
        s1_lines_q <= line_mem[in_col_q];
      end
    end
    if (s1_go) begin
      // newer row moves to older, new pixel becomes newer
      line_mem[s1_col_q] <= {s1_lines_q[0], s1_bot_q};
    end
    if (res_load) begin
      res_pix_q  <= acc;
      res_row_q  <= bm3_pkg::COORD_W'(out_row_q);
      res_col_q  <= bm3_pkg::COORD_W'(out_col_q);
      res_last_q <= out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = res_pix_q;
  assign result_row_o   = res_row_q;
  assign result_col_o   = res_col_q;
  assign frame_last_o   = res_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BM3_ASSERT(a_in_col_range, clk_i, rst_ni, 32'(in_col_q) < 32'(eff_w_q))
  `BM3_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_go,
                   s1_valid_q && $stable(s1_col_q) && $stable(s1_bot_q))
  `BM3_ASSERT_NEXT(a_result_load, clk_i, rst_ni, res_load, out_valid_q)

endmodule
